[design/fba_pkg.sv]
`timescale 1ns / 1ps
// shared constants, field widths and codes of the frame bitmap allocator
package fba_pkg;

	localparam int DEF_MAX_FRAMES = 32768;
	localparam int DEF_WORD_BITS  = 32;

	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int FRAME_W    = 15;
	localparam int PAGE_SHIFT = 12;
	localparam int ADDR_W     = FRAME_W + PAGE_SHIFT;
	localparam int CFG_W      = 16;
	localparam int S_DATA_W   = 16;
	localparam int M_DATA_W   = 48;

	localparam int CFG_RESET  = 32768;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_MARK  = 2'd2;
	localparam logic [OP_W-1:0] OP_TEST  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

endpackage

[design/fba_div.sv]
`timescale 1ns / 1ps
// two-stage split of a frame number into bitmap word index and bit index
module fba_div import fba_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS,
	parameter int WIDX_W    = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [FRAME_W-1:0]          fn,
	output logic                        done,
	output logic [WIDX_W-1:0]           word_idx,
	output logic [$clog2(WORD_BITS)-1:0] bit_idx
);

	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int SH    = FRAME_W + BIT_W;
	localparam int PW    = FRAME_W + SH + 1;
	localparam int QW    = FRAME_W + BIT_W + 1;
	// rounded-up reciprocal, exact for every frame number of FRAME_W bits
	localparam logic [SH:0] RECIP = (SH+1)'((2**SH + WORD_BITS - 1) / WORD_BITS);

	logic [PW-1:0]      prod;
	logic [FRAME_W-1:0] q_s1;
	logic [FRAME_W-1:0] fn_s1;
	logic               v_s1;
	logic [QW-1:0]      qw;
	logic [QW-1:0]      rem;
	logic [WIDX_W-1:0]  word_s2;
	logic [BIT_W-1:0]   bit_s2;
	logic               v_s2;

	assign prod = PW'(fn) * PW'(RECIP);
	assign qw   = QW'(q_s1) * QW'(WORD_BITS);
	assign rem  = QW'(fn_s1) - qw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_s1  <= FRAME_W'(prod >> SH);
			fn_s1 <= fn;
		end
		if (v_s1) begin
			word_s2 <= WIDX_W'(q_s1);
			bit_s2  <= rem[BIT_W-1:0];
		end
	end

	assign done     = v_s2;
	assign word_idx = word_s2;
	assign bit_idx  = bit_s2;

endmodule

[design/frame_bitmap_allocator_top.sv]
`timescale 1ns / 1ps
// first-fit page frame allocator over a usage bitmap held in one memory
// allocate reads the bitmap words in turn, then steps through the bits of the first word
//   that is not full, or reports none free after the last word; free, mark and test split
//   the frame number and read its word, free and mark write it back; out of range goes to the result
// one request in flight; the next is taken once its result sits in the output register
// after reset a fill pass writes all ones to every word (1024 words at defaults)
//   while s_tready stays low; frame_count writes are taken at any time
module frame_bitmap_allocator_top import fba_pkg::*; #(
	parameter int MAX_FRAMES = DEF_MAX_FRAMES,
	parameter int WORD_BITS  = DEF_WORD_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // frame_number [14:0], zero fill
	input  logic [OP_W-1:0]     s_tuser,   // opcode [1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // result_frame [14:0], frame_address [41:15],
	                                       // was_used [42], zero fill
	output logic [STATUS_W-1:0] m_tuser,   // status [1:0]
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data
);

	localparam int WORD_COUNT = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int CNT_W      = $clog2(MAX_FRAMES + 2 * WORD_BITS);
	localparam int LIM_RESET  = (CFG_RESET > MAX_FRAMES) ? MAX_FRAMES : CFG_RESET;
	localparam int PAD_W      = M_DATA_W - FRAME_W - ADDR_W - 1;
	localparam logic [WIDX_W-1:0]    CLR_LAST  = WIDX_W'(WORD_COUNT - 1);
	localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_BITS = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_MOD  = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     lim_q;
	logic [WIDX_W-1:0]    clr_q;
	logic [WIDX_W:0]      w_q;
	logic [CNT_W-1:0]     base_q;
	logic                 chk_valid_q;
	logic [OP_W-1:0]      op_q;
	logic [FRAME_W-1:0]   fn_q;
	logic [WIDX_W-1:0]    pend_w_q;
	logic [CNT_W-1:0]     pend_base_q;
	logic [WORD_BITS-1:0] word_q;
	logic [WIDX_W-1:0]    widx_q;
	logic [CNT_W-1:0]     f_q;
	logic [BIT_W-1:0]     b_q;

	logic [STATUS_W-1:0]  res_status_q;
	logic [FRAME_W-1:0]   res_frame_q;
	logic                 res_used_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [FRAME_W-1:0]   out_frame_q;
	logic                 out_used_q;

	logic [WORD_BITS-1:0] mem [WORD_COUNT];
	logic [WORD_BITS-1:0] rdata_q;
	logic                 mem_we;
	logic                 mem_re;
	logic [WIDX_W-1:0]    waddr;
	logic [WIDX_W-1:0]    raddr;
	logic [WORD_BITS-1:0] wdata;

	logic                 div_start;
	logic                 div_done;
	logic [WIDX_W-1:0]    div_word;
	logic [BIT_W-1:0]     div_bit;

	logic                 in_accept;
	logic [FRAME_W-1:0]   in_fn;
	logic                 in_range;
	logic                 can_issue;
	logic                 hit;
	logic                 f_in;
	logic                 emit_go;
	logic [CNT_W-1:0]     cfg_lim;

	assign in_fn     = s_tdata[FRAME_W-1:0];
	assign s_tready  = (state_q == S_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign in_range  = 32'(in_fn) < 32'(lim_q);
	assign can_issue = (w_q < (WIDX_W+1)'(WORD_COUNT)) && (base_q < lim_q);
	assign hit       = chk_valid_q && (rdata_q != WORD_ONES);
	assign f_in      = f_q < lim_q;
	assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || m_tready);
	assign cfg_ready = 1'b1;
	assign cfg_lim   = (32'(cfg_data) > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
	                                                      : CNT_W'(cfg_data);

	fba_div #(
		.WORD_BITS(WORD_BITS),
		.WIDX_W   (WIDX_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.fn      (in_fn),
		.done    (div_done),
		.word_idx(div_word),
		.bit_idx (div_bit)
	);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		waddr     = widx_q;
		raddr     = w_q[WIDX_W-1:0];
		wdata     = word_q | (WORD_BITS'(1) << b_q);
		div_start = 1'b0;
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
				waddr  = clr_q;
				wdata  = WORD_ONES;
			end
			S_IDLE: begin
				div_start = in_accept && (s_tuser != OP_ALLOC) && in_range;
			end
			S_SCAN: begin
				mem_re = !hit && can_issue;
			end
			S_BITS: begin
				mem_we = f_in && !word_q[b_q];
			end
			S_DIV: begin
				mem_re = div_done;
				raddr  = div_word;
			end
			S_MOD: begin
				mem_we = (op_q == OP_FREE) || (op_q == OP_MARK);
				waddr  = div_word;
				if (op_q == OP_FREE) begin
					wdata = rdata_q & ~(WORD_BITS'(1) << div_bit);
				end else begin
					wdata = rdata_q | (WORD_BITS'(1) << div_bit);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			lim_q       <= CNT_W'(LIM_RESET);
			w_q         <= '0;
			base_q      <= '0;
			chk_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				lim_q <= cfg_lim;
			end
			out_valid_q <= emit_go || (out_valid_q && !m_tready);
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						if (s_tuser == OP_ALLOC) begin
							state_q     <= S_SCAN;
							w_q         <= '0;
							base_q      <= '0;
							chk_valid_q <= 1'b0;
						end else if (in_range) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_SCAN: begin
					// read one word per cycle, check the word read the cycle before
					if (hit) begin
						state_q <= S_BITS;
					end else if (can_issue) begin
						w_q         <= w_q + 1'b1;
						base_q      <= base_q + CNT_W'(WORD_BITS);
						chk_valid_q <= 1'b1;
					end else if (chk_valid_q) begin
						chk_valid_q <= 1'b0;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_BITS: begin
					if (!f_in || !word_q[b_q]) begin
						state_q <= S_EMIT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request fields, scan word and result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					op_q         <= s_tuser;
					fn_q         <= in_fn;
					res_status_q <= ST_RANGE;
					res_frame_q  <= in_fn;
					res_used_q   <= 1'b0;
				end
			end
			S_SCAN: begin
				if (hit) begin
					word_q <= rdata_q;
					widx_q <= pend_w_q;
					f_q    <= pend_base_q;
					b_q    <= '0;
				end else if (can_issue) begin
					pend_w_q    <= w_q[WIDX_W-1:0];
					pend_base_q <= base_q;
				end else if (!chk_valid_q) begin
					res_status_q <= ST_NO_FREE;
					res_frame_q  <= '0;
					res_used_q   <= 1'b0;
				end
			end
			S_BITS: begin
				if (!f_in) begin
					res_status_q <= ST_NO_FREE;
					res_frame_q  <= '0;
					res_used_q   <= 1'b0;
				end else if (!word_q[b_q]) begin
					res_status_q <= ST_OK;
					res_frame_q  <= FRAME_W'(f_q);
					res_used_q   <= 1'b0;
				end else begin
					b_q <= b_q + 1'b1;
					f_q <= f_q + 1'b1;
				end
			end
			S_MOD: begin
				res_status_q <= ST_OK;
				res_frame_q  <= fn_q;
				res_used_q   <= rdata_q[div_bit];
			end
			default: begin
			end
		endcase
		if (emit_go) begin
			out_status_q <= res_status_q;
			out_frame_q  <= res_frame_q;
			out_used_q   <= res_used_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_used_q, out_frame_q, {PAGE_SHIFT{1'b0}}, out_frame_q};

	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == S_EMIT)
		else $error("result shown without passing the emit step");

	a_alloc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BITS && mem_we) |-> (f_q < lim_q))
		else $error("allocation wrote a frame at or above the frame count");

	a_fill_complete: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == S_CLR && state_q == S_IDLE) |-> $past(clr_q) == CLR_LAST)
		else $error("fill pass ended before the last bitmap word");

	a_modify_after_split: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD) |-> $past(div_done))
		else $error("bitmap word modified without a finished index split");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// testbench of the frame bitmap allocator: directed and random requests checked against a bitmap predictor
module tb_top;
	import fba_pkg::*;

	localparam int MAP_WORDS   = DEF_MAX_FRAMES / DEF_WORD_BITS;
	localparam int STALL_LIMIT = 10000;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  frame;
		logic [ADDR_W-1:0]   addr;
		logic                was_used;
	} frame_result_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [OP_W-1:0]     s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data;

	logic [DEF_WORD_BITS-1:0] usage_map [MAP_WORDS];
	logic [CFG_W-1:0]         frame_count_shadow;
	frame_result_t            pending_results [$];
	int                       mismatch_count;
	int                       stall_cycles;
	bit                       steady;

	frame_bitmap_allocator_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// first-fit search and bit updates on the shadow bitmap
	function automatic frame_result_t predict_frame_op(input logic [OP_W-1:0] op,
			input logic [FRAME_W-1:0] fn);
		frame_result_t r;
		int lim;
		int f;
		lim = (int'(frame_count_shadow) > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES
			: int'(frame_count_shadow);
		r = '0;
		if (op == OP_ALLOC) begin
			r.status = ST_NO_FREE;
			for (int w = 0; w < MAP_WORDS && w * DEF_WORD_BITS < lim; w++) begin
				if (usage_map[w] == '1)
					continue;
				for (int b = 0; b < DEF_WORD_BITS; b++) begin
					f = w * DEF_WORD_BITS + b;
					if (f >= lim)
						break;
					if (!usage_map[w][b]) begin
						usage_map[w][b] = 1'b1;
						r.status = ST_OK;
						r.frame  = FRAME_W'(f);
						r.addr   = ADDR_W'(FRAME_W'(f)) << PAGE_SHIFT;
						return r;
					end
				end
			end
			return r;
		end
		r.frame = fn;
		r.addr  = ADDR_W'(fn) << PAGE_SHIFT;
		if (int'(fn) >= lim) begin
			r.status = ST_RANGE;
			return r;
		end
		r.status   = ST_OK;
		r.was_used = usage_map[fn / DEF_WORD_BITS][fn % DEF_WORD_BITS];
		if (op == OP_FREE)
			usage_map[fn / DEF_WORD_BITS][fn % DEF_WORD_BITS] = 1'b0;
		else if (op == OP_MARK)
			usage_map[fn / DEF_WORD_BITS][fn % DEF_WORD_BITS] = 1'b1;
		return r;
	endfunction

	task automatic issue_frame_request(input logic [OP_W-1:0] op, input int fn);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 8) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'(FRAME_W'(fn));
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(predict_frame_op(op, FRAME_W'(fn)));
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_frame_count(input int value);
		wait_all_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= CFG_W'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		frame_count_shadow = CFG_W'(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// whole map used after reset, default count
	task automatic test_reset_state();
		issue_frame_request(OP_ALLOC, 0);
		issue_frame_request(OP_TEST, 0);
		issue_frame_request(OP_TEST, DEF_MAX_FRAMES - 1);
	endtask

	task automatic test_free_mark_alloc();
		issue_frame_request(OP_FREE, 0);
		issue_frame_request(OP_FREE, DEF_MAX_FRAMES - 1);
		issue_frame_request(OP_ALLOC, 0);
		issue_frame_request(OP_ALLOC, 0);
		// double free and double mark only report the old bit
		issue_frame_request(OP_FREE, 7);
		issue_frame_request(OP_FREE, 7);
		issue_frame_request(OP_MARK, 7);
		issue_frame_request(OP_MARK, 7);
		issue_frame_request(OP_TEST, 7);
	endtask

	task automatic test_count_extremes();
		write_frame_count(0);
		issue_frame_request(OP_ALLOC, 0);
		issue_frame_request(OP_TEST, 0);
		// oversized count behaves as the full map
		write_frame_count(65535);
		issue_frame_request(OP_TEST, DEF_MAX_FRAMES - 1);
		issue_frame_request(OP_FREE, DEF_MAX_FRAMES - 1);
		issue_frame_request(OP_ALLOC, 0);
	endtask

	task automatic test_partial_and_shrunk_count();
		write_frame_count(40);
		issue_frame_request(OP_FREE, 39);
		issue_frame_request(OP_TEST, 40);
		issue_frame_request(OP_ALLOC, 0);
		issue_frame_request(OP_ALLOC, 0);
		issue_frame_request(OP_FREE, 35);
		// frame 35 stays free but drops out of reach
		write_frame_count(33);
		issue_frame_request(OP_ALLOC, 0);
		issue_frame_request(OP_TEST, 35);
		write_frame_count(40);
		issue_frame_request(OP_TEST, 35);
	endtask

	task automatic run_traffic_phase(input int count, input int n_requests, input bit no_idle);
		int lim;
		int pick;
		int fn;
		logic [OP_W-1:0] op;
		write_frame_count(count);
		steady = no_idle;
		lim = (count > DEF_MAX_FRAMES) ? DEF_MAX_FRAMES : count;
		for (int i = 0; i < n_requests; i++) begin
			pick = $urandom_range(0, 99);
			fn   = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
			if (pick < 35)
				op = OP_ALLOC;
			else if (pick < 60)
				op = OP_FREE;
			else if (pick < 75)
				op = OP_MARK;
			else if (pick < 90)
				op = OP_TEST;
			else begin
				// noise: any code, any frame number, mostly out of range
				op = OP_W'($urandom);
				fn = $urandom_range(0, DEF_MAX_FRAMES - 1);
			end
			if (lim == 0)
				fn = $urandom_range(0, DEF_MAX_FRAMES - 1);
			issue_frame_request(op, fn);
		end
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(64, 70, 1'b0);
		run_traffic_phase(1, 20, 1'b0);
		run_traffic_phase(33, 50, 1'b0);
		run_traffic_phase($urandom_range(100, 1000), 100, 1'b1);
		run_traffic_phase(300, 100, 1'b0);
		run_traffic_phase(DEF_MAX_FRAMES, 60, 1'b0);
		run_traffic_phase(65535, 40, 1'b0);
		run_traffic_phase($urandom_range(0, 65535), 40, 1'b0);
		run_traffic_phase(97, 80, 1'b0);
	endtask

	always @(negedge clk)
		m_tready <= steady || ($urandom_range(0, 99) >= 8);

	always @(posedge clk) begin
		frame_result_t exp_r;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result without a pending request: status %0d frame %0d",
					m_tuser, m_tdata[FRAME_W-1:0]);
				mismatch_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tuser !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, m_tuser);
					mismatch_count++;
				end
				if (m_tdata[FRAME_W-1:0] !== exp_r.frame) begin
					$error("result_frame: expected %0d, got %0d", exp_r.frame,
						m_tdata[FRAME_W-1:0]);
					mismatch_count++;
				end
				if (m_tdata[FRAME_W+ADDR_W-1:FRAME_W] !== exp_r.addr) begin
					$error("frame_address: expected 0x%0h, got 0x%0h", exp_r.addr,
						m_tdata[FRAME_W+ADDR_W-1:FRAME_W]);
					mismatch_count++;
				end
				if (m_tdata[FRAME_W+ADDR_W] !== exp_r.was_used) begin
					$error("was_used: expected %0d, got %0d", exp_r.was_used,
						m_tdata[FRAME_W+ADDR_W]);
					mismatch_count++;
				end
			end
		end
	end

	// covers the fill pass after reset and the longest allocate scan
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = OP_ALLOC;
		m_tready       = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		steady         = 1'b0;
		mismatch_count = 0;
		stall_cycles   = 0;
		frame_count_shadow = CFG_W'(CFG_RESET);
		for (int w = 0; w < MAP_WORDS; w++)
			usage_map[w] = '1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_free_mark_alloc();
		test_count_extremes();
		test_partial_and_shrunk_count();
		test_random_traffic();

		wait_all_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
design/fba_pkg.sv
design/fba_div.sv
design/frame_bitmap_allocator_top.sv
sim/tb_top.sv
